@@ rtl/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int DIM       = 4;
  localparam int ELEMS     = DIM * DIM;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = $clog2(ELEMS);
  // exact sum of DIM products of two signed 32-bit values
  localparam int ACC_W  = 2 * DATA_W + $clog2(DIM);

  typedef struct packed {
    logic signed [DATA_W-1:0] a_elem;
    logic signed [DATA_W-1:0] b_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_elem;
    logic                     last_result;
    logic                     saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              load_en;
    logic [ADDR_W-1:0] load_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  k;
    logic              first;
    logic              last_k;
    logic              last_elem;
  } mm4_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_valid;
    logic out_load;
  } mm4_stat_t;

endpackage

`default_nettype wire

@@ rtl/matrix4_multiply_top.sv @@
// ----------------------------------------------------------------------------
// matrix4_multiply_top
// Streaming 4x4 signed Q16.16 matrix product C = A * B.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready/item): each item carries one element
// of A and the same-position element of B, row-major. Sixteen items load one
// matrix pair, one item per cycle while loading.
// Output channel (result_valid/result_ready/result): the sixteen elements of
// C in row-major order; last_result marks the sixteenth, saturated marks an
// element whose floored sum did not fit in 32 bits.
// Datapath: one shared multiply-accumulate unit does four multiplies per
// element; each element is issued into the 3-stage read/multiply/accumulate
// pipeline and then the output register; the next element is issued only
// once the pipeline has drained.
// Loading of the next pair starts while the last result still waits.
// Reset: clears the load count and sequencer; the operand stores keep no
// reset value and are fully written before use.
// Stall: the output register holds its result; the next element is not
// started until the register is free, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_multiply_top
  import mm4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result
);

  mm4_cmd_t  cmd;
  mm4_stat_t stat;

  mm4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  mm4_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .result_ready (result_ready),
    .result       (result),
    .result_valid (result_valid),
    .stat         (stat)
  );

  // no load while a dot product is in flight
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !item_ready)
    else $error("input accepted while datapath busy");

  // a finished element never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.out_load |-> (!$past(result_valid) || $past(result_ready)) || !result_valid)
    else $error("output register overwritten");

  // a new dot product only starts once the previous one has drained
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.first) |-> !stat.busy)
    else $error("dot product started while pipeline busy");

endmodule

`default_nettype wire

@@ rtl/mm4_ctrl.sv @@
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: loads the operand stores, then walks row, column and dot-product
// index over the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_ctrl
  import mm4_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire logic      result_ready,
  input  wire mm4_stat_t stat,
  output mm4_cmd_t       cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(DIM - 1);
  localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(ELEMS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [ADDR_W-1:0] load_count;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  k;
  logic              out_free;
  logic              last_k;
  logic              last_elem;
  logic              load_fire;

  assign out_free   = !stat.out_valid || result_ready;
  assign last_k     = (k == IDX_LAST);
  assign last_elem  = (row == IDX_LAST) && (col == IDX_LAST);
  assign item_ready = (state == S_LOAD);
  assign load_fire  = item_valid && item_ready;

  always_comb begin
    cmd           = '0;
    cmd.load_en   = load_fire;
    cmd.load_addr = load_count;
    cmd.rd_en     = (state == S_ISSUE);
    cmd.row       = row;
    cmd.col       = col;
    cmd.k         = k;
    cmd.first     = (k == '0);
    cmd.last_k    = last_k;
    cmd.last_elem = last_elem;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (load_fire && load_count == LOAD_LAST) state_next = S_START;
      end
      S_START: begin
        if (out_free) state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (last_k) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.busy) begin
          if (last_elem)     state_next = S_LOAD;
          else if (out_free) state_next = S_ISSUE;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
    end else begin
      state <= state_next;
      if (load_fire) begin
        load_count <= (load_count == LOAD_LAST) ? '0 : load_count + 1'b1;
      end
      if (state == S_ISSUE) begin
        k <= last_k ? '0 : k + 1'b1;
      end
      // step to the next output element when leaving the wait
      if (state == S_WAIT && state_next != S_WAIT) begin
        if (col == IDX_LAST) begin
          col <= '0;
          row <= (row == IDX_LAST) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mm4_dp.sv @@
// ----------------------------------------------------------------------------
// mm4_dp
// Operand stores, one signed 32x32 multiplier, full-width accumulator and
// the shift/saturate output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_dp
  import mm4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire mm4_cmd_t cmd,
  input  wire logic     result_ready,
  output out_item_t     result,
  output logic          result_valid,
  output mm4_stat_t     stat
);

  logic signed [DATA_W-1:0] a_mem [ELEMS];
  logic signed [DATA_W-1:0] b_mem [ELEMS];

  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;

  // stage 1: store read
  logic signed [DATA_W-1:0] a_rd;
  logic signed [DATA_W-1:0] b_rd;
  logic s1_v, s1_first, s1_last_k, s1_last_elem;

  // stage 2: product
  logic signed [2*DATA_W-1:0] prod;
  logic s2_v, s2_first, s2_last_k, s2_last_elem;

  // stage 3: accumulate
  logic signed [ACC_W-1:0] acc;
  logic                    acc_done;
  logic                    acc_last_elem;

  logic signed [ACC_W-1:0] shifted;
  logic                    fits;

  assign a_addr = ADDR_W'(int'(cmd.row) * DIM + int'(cmd.k));
  assign b_addr = ADDR_W'(int'(cmd.k) * DIM + int'(cmd.col));

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      a_mem[cmd.load_addr] <= item.a_elem;
      b_mem[cmd.load_addr] <= item.b_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_rd <= a_mem[a_addr];
      b_rd <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_v     <= cmd.rd_en;
      s2_v     <= s1_v;
      acc_done <= s2_v && s2_last_k;
    end
  end

  always_ff @(posedge clk) begin
    s1_first     <= cmd.first;
    s1_last_k    <= cmd.last_k;
    s1_last_elem <= cmd.last_elem;
    s2_first     <= s1_first;
    s2_last_k    <= s1_last_k;
    s2_last_elem <= s1_last_elem;
    prod         <= a_rd * b_rd;
    if (s2_v) begin
      acc           <= s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
      acc_last_elem <= s2_last_elem;
    end
  end

  // floor shift back to the fixed-point scale, then range check
  assign shifted = acc >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_done) begin
      result.last_result <= acc_last_elem;
      result.saturated   <= !fits;
      if (fits) begin
        result.product_elem <= shifted[DATA_W-1:0];
      end else if (shifted[ACC_W-1]) begin
        result.product_elem <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        result.product_elem <= {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.busy      = s1_v || s2_v || acc_done;
    stat.out_valid = result_valid;
    stat.out_load  = acc_done;
  end

endmodule

`default_nettype wire
